// File: hdl/vdb_pkg.sv
package vdb_pkg;

    // Field and register widths.
    localparam int MODE_W    = 2;
    localparam int COORD_W   = 10;
    localparam int VALUE_W   = 16;
    localparam int VOX_W     = 11;
    localparam int CELLS_W   = 6;
    localparam int WEIGHT_W  = 32;
    localparam int DENS_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Grid store geometry.
    localparam int MAX_CELLS   = 32;
    localparam int CELL_BITS   = $clog2(MAX_CELLS);
    localparam int ADDR_W      = 3 * CELL_BITS;
    localparam int STORE_DEPTH = MAX_CELLS * MAX_CELLS * MAX_CELLS;
    localparam int COUNT_W     = 32;

    // Binning divider: the quotient is below the cells register, so it has
    // as many bits as that register.
    localparam int QUOT_W = CELLS_W;
    localparam int PROD_W = COORD_W + CELLS_W;
    localparam int STEP_W = $clog2(QUOT_W);

    // Register reset values.
    localparam logic [VOX_W-1:0]    VOXELS_RESET = VOX_W'(1024);
    localparam logic [CELLS_W-1:0]  CELLS_RESET  = CELLS_W'(32);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = '0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOXELS_X  = 3'd0,
        CFG_VOXELS_Y  = 3'd1,
        CFG_VOXELS_Z  = 3'd2,
        CFG_CELLS_X   = 3'd3,
        CFG_CELLS_Y   = 3'd4,
        CFG_CELLS_Z   = 3'd5,
        CFG_WEIGHT    = 3'd6
    } cfg_idx_t;

    // Item operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_ACCUM      = 2'd0,
        MODE_READ       = 2'd1,
        MODE_READ_CLEAR = 2'd2,
        MODE_NONE       = 2'd3
    } mode_t;

    // Control of one divider lane.
    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

endpackage

// File: hdl/vdb_if.sv
interface vdb_voxel_if;
    import vdb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [COORD_W-1:0]   coord_z;
    logic [VALUE_W-1:0]   voxel_value;

    modport source (output valid, mode, coord_x, coord_y, coord_z, voxel_value,
                    input ready);
    modport sink   (input valid, mode, coord_x, coord_y, coord_z, voxel_value,
                    output ready);
endinterface

interface vdb_cell_if;
    import vdb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COUNT_W-1:0]   cell_count;
    logic [DENS_W-1:0]    density;
    logic                 out_of_range;

    modport source (output valid, cell_count, density, out_of_range, input ready);
    modport sink   (input valid, cell_count, density, out_of_range, output ready);
endinterface

// File: hdl/voxel_density_binning.sv
// Occupancy histogram of a voxel volume on a grid of up to 32 cells per axis.
// After reset the block sweeps its 32768-entry count store to zero, one entry
// a cycle, and takes no item until the sweep is done; configuration writes
// are taken throughout. Configure only while the block is idle. An accumulate
// item with a nonzero value goes through the accept, six steps of the
// per-axis binning divider (three lanes side by side, one quotient bit each a
// cycle), a read of the count store and a write-back; the write-back is
// skipped when the voxel falls outside the volume or the store. A zero voxel
// or an unused mode is accepted and dropped. A read goes through store read,
// capture, density multiply and output load, an out-of-range read skips the
// store read and capture, and both wait at the output load only while the
// previous result has not been taken. One item is worked on at a time; the
// output register lets a new item be accepted while a result waits.
module voxel_density_binning (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [vdb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vdb_pkg::CFG_DATA_W-1:0] cfg_data,
    vdb_voxel_if.sink                      voxel_in,
    vdb_cell_if.source                     cell_out
);
    import vdb_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_DIV     = 8'b0000_0100,
        ST_ACC_RD  = 8'b0000_1000,
        ST_ACC_WR  = 8'b0001_0000,
        ST_RD_DATA = 8'b0010_0000,
        ST_DENS    = 8'b0100_0000,
        ST_RESULT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [VOX_W-1:0]    voxels_x_reg, voxels_y_reg, voxels_z_reg;
    logic [CELLS_W-1:0]  cells_x_reg, cells_y_reg, cells_z_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    // Sequencer registers.
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                clear_reg, clear_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                oor_reg, oor_next;
    logic [DENS_W-1:0]   dens_reg, dens_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [DENS_W-1:0]   out_dens_reg, out_dens_next;
    logic                out_oor_reg, out_oor_next;

    // Count store.
    logic [COUNT_W-1:0]  mem [STORE_DEPTH];
    logic [COUNT_W-1:0]  mem_q_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [COUNT_W-1:0]  mem_wdata;

    // Divider lanes.
    div_ctl_t            div_ctl;
    logic [QUOT_W-1:0]   quot_x, quot_y, quot_z;
    logic                hit_x, hit_y, hit_z;

    logic                accept;
    logic                slot_free;
    logic                read_ok;
    logic                bin_ok;
    mode_t               in_mode;

    assign in_mode   = mode_t'(voxel_in.mode);
    assign accept    = voxel_in.valid && voxel_in.ready;
    assign slot_free = !out_valid_reg || cell_out.ready;

    // A read cell must lie inside both the configured grid and the store.
    assign read_ok = (voxel_in.coord_x < COORD_W'(cells_x_reg)) &&
                     (voxel_in.coord_x < COORD_W'(MAX_CELLS)) &&
                     (voxel_in.coord_y < COORD_W'(cells_y_reg)) &&
                     (voxel_in.coord_y < COORD_W'(MAX_CELLS)) &&
                     (voxel_in.coord_z < COORD_W'(cells_z_reg)) &&
                     (voxel_in.coord_z < COORD_W'(MAX_CELLS));

    // A binned voxel must lie inside the volume and map inside the store.
    assign bin_ok = hit_x && hit_y && hit_z &&
                    (quot_x < QUOT_W'(MAX_CELLS)) &&
                    (quot_y < QUOT_W'(MAX_CELLS)) &&
                    (quot_z < QUOT_W'(MAX_CELLS));

    vdb_div_lane u_div_x (
        .clk    (clk),
        .ctl    (div_ctl),
        .coord  (voxel_in.coord_x),
        .cells  (cells_x_reg),
        .voxels (voxels_x_reg),
        .quot   (quot_x),
        .hit    (hit_x)
    );

    vdb_div_lane u_div_y (
        .clk    (clk),
        .ctl    (div_ctl),
        .coord  (voxel_in.coord_y),
        .cells  (cells_y_reg),
        .voxels (voxels_y_reg),
        .quot   (quot_y),
        .hit    (hit_y)
    );

    vdb_div_lane u_div_z (
        .clk    (clk),
        .ctl    (div_ctl),
        .coord  (voxel_in.coord_z),
        .cells  (cells_z_reg),
        .voxels (voxels_z_reg),
        .quot   (quot_z),
        .hit    (hit_z)
    );

    assign voxel_in.ready = (state_reg == ST_IDLE);

    // Sequencer: one item at a time through division, read and write-back, or a read.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        clear_next     = clear_reg;
        cnt_next       = cnt_reg;
        oor_next       = oor_reg;
        dens_next      = dens_reg;
        out_valid_next = out_valid_reg && !cell_out.ready;
        out_count_next = out_count_reg;
        out_dens_next  = out_dens_reg;
        out_oor_next   = out_oor_reg;
        div_ctl        = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = addr_reg;
        mem_raddr      = addr_reg;
        mem_wdata      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode) inside
                        MODE_ACCUM:
                        begin
                            if (voxel_in.voxel_value != '0)
                            begin
                                div_ctl.load = 1'b1;
                                step_next    = '0;
                                state_next   = ST_DIV;
                            end
                        end
                        MODE_READ, MODE_READ_CLEAR:
                        begin
                            clear_next = (in_mode == MODE_READ_CLEAR);
                            if (read_ok)
                            begin
                                addr_next  = {voxel_in.coord_z[CELL_BITS-1:0],
                                              voxel_in.coord_y[CELL_BITS-1:0],
                                              voxel_in.coord_x[CELL_BITS-1:0]};
                                mem_re     = 1'b1;
                                mem_raddr  = addr_next;
                                oor_next   = 1'b0;
                                state_next = ST_RD_DATA;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                oor_next   = 1'b1;
                                state_next = ST_DENS;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                div_ctl.step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUOT_W - 1))
                begin
                    state_next = ST_ACC_RD;
                end
            end
            ST_ACC_RD:
            begin
                if (bin_ok)
                begin
                    addr_next  = {quot_z[CELL_BITS-1:0], quot_y[CELL_BITS-1:0],
                                  quot_x[CELL_BITS-1:0]};
                    mem_re     = 1'b1;
                    mem_raddr  = addr_next;
                    state_next = ST_ACC_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC_WR:
            begin
                // Saturating increment written back to the entry just read.
                mem_we    = 1'b1;
                mem_wdata = (mem_q_reg == {COUNT_W{1'b1}}) ? mem_q_reg
                                                           : mem_q_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD_DATA:
            begin
                cnt_next = mem_q_reg;
                mem_we   = clear_reg;
                state_next = ST_DENS;
            end
            ST_DENS:
            begin
                dens_next  = DENS_W'(cnt_reg) * DENS_W'(weight_reg);
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = cnt_reg;
                    out_dens_next  = dens_reg;
                    out_oor_next   = oor_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        clear_reg     <= clear_next;
        cnt_reg       <= cnt_next;
        oor_reg       <= oor_next;
        dens_reg      <= dens_next;
        out_count_reg <= out_count_next;
        out_dens_reg  <= out_dens_next;
        out_oor_reg   <= out_oor_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voxels_x_reg <= VOXELS_RESET;
            voxels_y_reg <= VOXELS_RESET;
            voxels_z_reg <= VOXELS_RESET;
            cells_x_reg  <= CELLS_RESET;
            cells_y_reg  <= CELLS_RESET;
            cells_z_reg  <= CELLS_RESET;
            weight_reg   <= WEIGHT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VOXELS_X: voxels_x_reg <= cfg_data[VOX_W-1:0];
                CFG_VOXELS_Y: voxels_y_reg <= cfg_data[VOX_W-1:0];
                CFG_VOXELS_Z: voxels_z_reg <= cfg_data[VOX_W-1:0];
                CFG_CELLS_X:  cells_x_reg  <= cfg_data[CELLS_W-1:0];
                CFG_CELLS_Y:  cells_y_reg  <= cfg_data[CELLS_W-1:0];
                CFG_CELLS_Z:  cells_z_reg  <= cfg_data[CELLS_W-1:0];
                CFG_WEIGHT:   weight_reg   <= cfg_data[WEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Count store with one registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    assign cell_out.valid        = out_valid_reg;
    assign cell_out.cell_count   = out_count_reg;
    assign cell_out.density      = out_dens_reg;
    assign cell_out.out_of_range = out_oor_reg;

endmodule

// File: hdl/vdb_div_lane.sv
module vdb_div_lane (
    input  logic                        clk,
    input  vdb_pkg::div_ctl_t           ctl,
    input  logic [vdb_pkg::COORD_W-1:0] coord,
    input  logic [vdb_pkg::CELLS_W-1:0] cells,
    input  logic [vdb_pkg::VOX_W-1:0]   voxels,
    output logic [vdb_pkg::QUOT_W-1:0]  quot,
    output logic                        hit
);
    import vdb_pkg::*;

    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] dsr_reg, dsr_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              hit_reg, hit_next;

    // Restoring division of coord * cells by voxels, one quotient bit a step.
    // The divisor starts at voxels shifted to the top quotient bit.
    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        hit_next  = hit_reg;
        if (ctl.load)
        begin
            rem_next  = PROD_W'(coord) * PROD_W'(cells);
            dsr_next  = PROD_W'(voxels) << (QUOT_W - 1);
            quot_next = '0;
            hit_next  = {1'b0, coord} < voxels;
        end
        else if (ctl.step)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_next  = rem_reg - dsr_reg;
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            dsr_next = dsr_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
        hit_reg  <= hit_next;
    end

    assign quot = quot_reg;
    assign hit  = hit_reg;

endmodule

// File: hdl/vdb_checker.sv
module vdb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [vdb_pkg::MODE_W-1:0]    in_mode,
    input logic [vdb_pkg::VALUE_W-1:0]   in_value,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [vdb_pkg::COUNT_W-1:0]   out_count,
    input logic [vdb_pkg::DENS_W-1:0]    out_density,
    input logic                          out_oor
);
    import vdb_pkg::*;

    // The store is being swept after reset, so no item can be taken.
    assert property (@(posedge clk) $rose(rst_n) |-> !in_ready)
        else $error("item taken during the clearing sweep");

    // A nonzero voxel keeps the block busy for its division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_mode == MODE_ACCUM && in_value != '0)
        |=> !in_ready)
        else $error("ready while a voxel is being binned");

    // An out-of-range result carries zero count and zero density.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_oor) |-> (out_count == '0 && out_density == '0))
        else $error("out-of-range result with nonzero payload");

    // An empty cell has zero density.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_count == '0) |-> (out_density == '0))
        else $error("density without count");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_count) &&
                                       $stable(out_density) && $stable(out_oor)))
        else $error("stalled result changed");

endmodule

bind voxel_density_binning vdb_checker u_vdb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (voxel_in.valid),
    .in_ready    (voxel_in.ready),
    .in_mode     (voxel_in.mode),
    .in_value    (voxel_in.voxel_value),
    .out_valid   (cell_out.valid),
    .out_ready   (cell_out.ready),
    .out_count   (cell_out.cell_count),
    .out_density (cell_out.density),
    .out_oor     (cell_out.out_of_range)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import vdb_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CLK_PERIOD    = 2 * CLK_HALF;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int COORD_SPAN    = 1 << COORD_W;
    localparam int REPORT_LIMIT  = 10;

    // One expected cell read result.
    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [DENS_W-1:0]  density;
        logic               oor;
    } cell_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vdb_voxel_if voxel_ch ();
    vdb_cell_if  cell_ch ();

    voxel_density_binning DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .voxel_in  (voxel_ch),
        .cell_out  (cell_ch)
    );

    // Own copy of the grid registers and of the count store.
    logic [VOX_W-1:0]    grid_vox_x   = VOXELS_RESET;
    logic [VOX_W-1:0]    grid_vox_y   = VOXELS_RESET;
    logic [VOX_W-1:0]    grid_vox_z   = VOXELS_RESET;
    logic [CELLS_W-1:0]  grid_cells_x = CELLS_RESET;
    logic [CELLS_W-1:0]  grid_cells_y = CELLS_RESET;
    logic [CELLS_W-1:0]  grid_cells_z = CELLS_RESET;
    logic [WEIGHT_W-1:0] grid_weight  = WEIGHT_RESET;
    bit   [COUNT_W-1:0]  occupancy [STORE_DEPTH];

    cell_result_t pending_reads [$];
    int unsigned  mismatches = 0;
    bit           idle_on    = 1'b1;
    logic         sink_held  = 1'b0;
    int unsigned  ready_gap  = 0;
    event         hold_off_request;

    // Clock.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Map one voxel coordinate onto its cell along one axis.
    function automatic bit map_to_cell(input logic [COORD_W-1:0] coord,
                                       input logic [VOX_W-1:0] voxels,
                                       input logic [CELLS_W-1:0] cells,
                                       output int unsigned cell_no);
        int unsigned q;
        cell_no = 0;
        if (voxels == 0 || coord >= voxels)
            return 1'b0;
        q = (32'(coord) * 32'(cells)) / 32'(voxels);
        if (q >= MAX_CELLS)
            return 1'b0;
        cell_no = q;
        return 1'b1;
    endfunction

    function automatic bit cell_in_grid(input logic [COORD_W-1:0] c,
                                        input logic [CELLS_W-1:0] cells);
        return (c < cells) && (32'(c) < MAX_CELLS);
    endfunction

    // Bin a voxel into the histogram, or work out the result of a cell read.
    function automatic void bin_or_read(input mode_t mode,
                                        input logic [COORD_W-1:0] cx,
                                        input logic [COORD_W-1:0] cy,
                                        input logic [COORD_W-1:0] cz,
                                        input logic [VALUE_W-1:0] value);
        int unsigned gx, gy, gz, idx;
        cell_result_t res;
        case (mode) inside
            MODE_ACCUM:
            begin
                if (value != 0 && map_to_cell(cx, grid_vox_x, grid_cells_x, gx)
                    && map_to_cell(cy, grid_vox_y, grid_cells_y, gy)
                    && map_to_cell(cz, grid_vox_z, grid_cells_z, gz))
                begin
                    idx = (gz * MAX_CELLS + gy) * MAX_CELLS + gx;
                    if (occupancy[idx] != '1)
                        occupancy[idx]++;
                end
            end
            MODE_READ, MODE_READ_CLEAR:
            begin
                if (!cell_in_grid(cx, grid_cells_x) || !cell_in_grid(cy, grid_cells_y)
                    || !cell_in_grid(cz, grid_cells_z))
                begin
                    res.count   = '0;
                    res.density = '0;
                    res.oor     = 1'b1;
                end
                else
                begin
                    idx = (32'(cz) * MAX_CELLS + 32'(cy)) * MAX_CELLS + 32'(cx);
                    res.count   = occupancy[idx];
                    res.density = DENS_W'(res.count) * DENS_W'(grid_weight);
                    res.oor     = 1'b0;
                    if (mode == MODE_READ_CLEAR)
                        occupancy[idx] = '0;
                end
                pending_reads.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Write one register; bits above a narrow register carry random junk.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] word;
        word = value;
        case (idx) inside
            CFG_VOXELS_X, CFG_VOXELS_Y, CFG_VOXELS_Z:
                word[CFG_DATA_W-1:VOX_W] = (CFG_DATA_W - VOX_W)'($urandom());
            CFG_CELLS_X, CFG_CELLS_Y, CFG_CELLS_Z:
                word[CFG_DATA_W-1:CELLS_W] = (CFG_DATA_W - CELLS_W)'($urandom());
            default: ;
        endcase
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        case (idx)
            CFG_VOXELS_X: grid_vox_x   = word[VOX_W-1:0];
            CFG_VOXELS_Y: grid_vox_y   = word[VOX_W-1:0];
            CFG_VOXELS_Z: grid_vox_z   = word[VOX_W-1:0];
            CFG_CELLS_X:  grid_cells_x = word[CELLS_W-1:0];
            CFG_CELLS_Y:  grid_cells_y = word[CELLS_W-1:0];
            CFG_CELLS_Z:  grid_cells_z = word[CELLS_W-1:0];
            CFG_WEIGHT:   grid_weight  = word[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // Set up the whole grid; the block must be idle.
    task automatic apply_grid(input logic [VOX_W-1:0] vx, input logic [VOX_W-1:0] vy,
                              input logic [VOX_W-1:0] vz, input logic [CELLS_W-1:0] cx,
                              input logic [CELLS_W-1:0] cy, input logic [CELLS_W-1:0] cz,
                              input logic [WEIGHT_W-1:0] weight);
        write_reg(CFG_VOXELS_X, CFG_DATA_W'(vx));
        write_reg(CFG_VOXELS_Y, CFG_DATA_W'(vy));
        write_reg(CFG_VOXELS_Z, CFG_DATA_W'(vz));
        write_reg(CFG_CELLS_X, CFG_DATA_W'(cx));
        write_reg(CFG_CELLS_Y, CFG_DATA_W'(cy));
        write_reg(CFG_CELLS_Z, CFG_DATA_W'(cz));
        write_reg(CFG_WEIGHT, CFG_DATA_W'(weight));
        cfg_wen <= 1'b0;
    endtask

    // Offer one item, wait for its acceptance and predict its effect.
    task automatic send_item(input mode_t mode, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz,
                             input logic [VALUE_W-1:0] value);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            voxel_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        voxel_ch.valid       <= 1'b1;
        voxel_ch.mode        <= mode;
        voxel_ch.coord_x     <= cx;
        voxel_ch.coord_y     <= cy;
        voxel_ch.coord_z     <= cz;
        voxel_ch.voxel_value <= value;
        do
            @(posedge clk);
        while (!voxel_ch.ready);
        bin_or_read(mode, cx, cy, cz, value);
    endtask

    // Stop offering, wait for every read result, then let the last voxel finish.
    task automatic drain;
        voxel_ch.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] coord_within(input logic [VOX_W-1:0] extent);
        int unsigned lim;
        if (extent == 0)
            return COORD_W'($urandom());
        lim = (extent > COORD_SPAN) ? COORD_SPAN : extent;
        return COORD_W'($urandom_range(0, lim - 1));
    endfunction

    // A cell coordinate, now and then just past the grid.
    function automatic logic [COORD_W-1:0] cell_within(input logic [CELLS_W-1:0] cells);
        int unsigned lim;
        if (cells == 0)
            return COORD_W'($urandom_range(0, 3));
        lim = (cells > MAX_CELLS) ? MAX_CELLS : cells;
        if ($urandom_range(0, 7) == 0)
            return COORD_W'(lim);
        return COORD_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [CELLS_W-1:0] pick_cells;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return CELLS_W'($urandom_range(1, 4));
        if (roll < 90)
            return CELLS_W'($urandom_range(5, MAX_CELLS));
        if (roll < 95)
            return '0;
        return CELLS_W'($urandom_range(MAX_CELLS + 1, (1 << CELLS_W) - 1));
    endfunction

    function automatic logic [VOX_W-1:0] pick_voxels;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return VOX_W'($urandom_range(1, 64));
        if (roll < 85)
            return VOX_W'($urandom_range(65, (1 << VOX_W) - 1));
        if (roll < 90)
            return '0;
        if (roll < 95)
            return '1;
        return VOX_W'(COORD_SPAN);
    endfunction

    task automatic random_grid;
        logic [WEIGHT_W-1:0] weight;
        case ($urandom_range(0, 3))
            0:       weight = '0;
            1:       weight = '1;
            default: weight = $urandom();
        endcase
        apply_grid(pick_voxels(), pick_voxels(), pick_voxels(),
                   pick_cells(), pick_cells(), pick_cells(), weight);
    endtask

    // Mostly voxels inside the volume and reads of real cells; the rest is noise.
    task automatic send_random_item;
        int unsigned pick;
        mode_t mode;
        logic [COORD_W-1:0] cx, cy, cz;
        logic [VALUE_W-1:0] value;
        pick  = $urandom_range(0, 99);
        cx    = COORD_W'($urandom());
        cy    = COORD_W'($urandom());
        cz    = COORD_W'($urandom());
        value = VALUE_W'($urandom());
        if (pick < 60)
        begin
            mode = MODE_ACCUM;
            cx = coord_within(grid_vox_x);
            cy = coord_within(grid_vox_y);
            cz = coord_within(grid_vox_z);
            if ($urandom_range(0, 9) == 0)
                value = '0;
        end
        else if (pick < 88)
        begin
            mode = (pick < 76) ? MODE_READ : MODE_READ_CLEAR;
            cx = cell_within(grid_cells_x);
            cy = cell_within(grid_cells_y);
            cz = cell_within(grid_cells_z);
        end
        else
            mode = mode_t'($urandom_range(0, 3));
        send_item(mode, cx, cy, cz, value);
    endtask

    // Reads and a voxel under the reset values of the registers.
    task automatic test_reset_defaults;
        send_item(MODE_READ, 0, 0, 0, 16'h0000);
        send_item(MODE_ACCUM, 10'd1023, 10'd0, 10'd512, 16'h0001);
        send_item(MODE_READ, 10'd31, 10'd0, 10'd16, 16'hFFFF);
        drain();
    endtask

    // Full grid: extreme voxels, zero voxel, unused mode, clearing and reads off the grid.
    task automatic test_accumulate_and_read;
        apply_grid(VOX_W'(COORD_SPAN), VOX_W'(COORD_SPAN), VOX_W'(COORD_SPAN),
                   CELLS_W'(MAX_CELLS), CELLS_W'(MAX_CELLS), CELLS_W'(MAX_CELLS), '1);
        send_item(MODE_ACCUM, '1, '1, '1, 16'hFFFF);
        send_item(MODE_ACCUM, 0, 0, 0, 16'h0001);
        send_item(MODE_ACCUM, 0, 0, 0, 16'h0001);
        send_item(MODE_ACCUM, 0, 0, 0, 16'h0000);
        send_item(MODE_NONE, 0, 0, 0, 16'h0007);
        send_item(MODE_ACCUM, '1, '1, '1, 16'h8000);
        send_item(MODE_READ, 0, 0, 0, 16'h0000);
        send_item(MODE_READ_CLEAR, 10'd31, 10'd31, 10'd31, 16'h0000);
        send_item(MODE_READ, 10'd31, 10'd31, 10'd31, 16'h0000);
        send_item(MODE_READ, 10'd32, 0, 0, 16'h0000);
        send_item(MODE_READ, 0, '1, 0, 16'h0000);
        send_item(MODE_READ_CLEAR, 0, 0, '1, 16'h0000);
        drain();
    endtask

    // Empty volume, zero cells, cells beyond the store and the widest volume.
    task automatic test_degenerate_grids;
        apply_grid('0, '1, VOX_W'(1), '0, '1, CELLS_W'(1), 32'h0000_0001);
        send_item(MODE_ACCUM, 0, 0, 0, 16'h0001);
        drain();
        apply_grid(VOX_W'(COORD_SPAN), VOX_W'(64), '1, '0, '1, CELLS_W'(1), 32'h8000_0000);
        send_item(MODE_ACCUM, 10'd700, 10'd40, 10'd1023, 16'h0001);
        send_item(MODE_ACCUM, 10'd700, 10'd20, 10'd1023, 16'h0003);
        send_item(MODE_ACCUM, 10'd5, 10'd64, 0, 16'h0001);
        send_item(MODE_READ, 0, 10'd19, 0, 16'h0000);
        drain();
        apply_grid(VOX_W'(COORD_SPAN), VOX_W'(64), '1, CELLS_W'(1), '1, CELLS_W'(1),
                   32'h8000_0000);
        send_item(MODE_READ, 0, 10'd19, 0, 16'h0000);
        send_item(MODE_READ, 0, 10'd40, 0, 16'h0000);
        send_item(MODE_READ_CLEAR, 0, 10'd19, 0, 16'h0000);
        drain();
    endtask

    // Phases of random items, each under its own grid.
    task automatic test_random_grids;
        repeat (10)
        begin
            random_grid();
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (40) send_random_item();
            drain();
        end
    endtask

    // The receiver holds off for a long stretch while reads keep coming.
    task automatic test_output_backpressure;
        idle_on = 1'b0;
        apply_grid(VOX_W'(8), VOX_W'(8), VOX_W'(8), CELLS_W'(2), CELLS_W'(2), CELLS_W'(2),
                   $urandom());
        repeat (12) send_random_item();
        -> hold_off_request;
        repeat (30)
            send_item($urandom_range(0, 1) ? MODE_READ : MODE_READ_CLEAR,
                      cell_within(grid_cells_x), cell_within(grid_cells_y),
                      cell_within(grid_cells_z), VALUE_W'($urandom()));
        drain();
    endtask

    // A closing stretch at full rate with no idling on either side.
    task automatic test_steady_stream;
        idle_on = 1'b0;
        random_grid();
        repeat (60) send_random_item();
        drain();
    endtask

    // Receiver: random stall bursts, or the long hold-off when asked.
    always @(posedge clk)
    begin
        if (sink_held)
            cell_ch.ready <= 1'b0;
        else if (ready_gap > 0)
        begin
            cell_ch.ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            cell_ch.ready <= 1'b0;
            ready_gap <= $urandom_range(0, 4);
        end
        else
            cell_ch.ready <= 1'b1;
    end

    // The long hold-off, counted in cycles.
    always
    begin
        @(hold_off_request);
        @(posedge clk);
        sink_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_held <= 1'b0;
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && cell_ch.valid && cell_ch.ready)
        begin
            if (pending_reads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected cell result: count %h density %h out_of_range %b",
                             cell_ch.cell_count, cell_ch.density, cell_ch.out_of_range);
            end
            else
            begin
                want = pending_reads.pop_front();
                if (want.count !== cell_ch.cell_count || want.density !== cell_ch.density
                    || want.oor !== cell_ch.out_of_range)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("cell result mismatch: expected %h %h %b, got %h %h %b",
                                 want.count, want.density, want.oor, cell_ch.cell_count,
                                 cell_ch.density, cell_ch.out_of_range);
                end
            end
        end
    end

    // Overall time limit.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAIL voxel_density_binning");
        $finish;
    end

    // Reset, then the tests in turn.
    initial
    begin
        rst_n                <= 1'b0;
        cfg_wen              <= 1'b0;
        cfg_index            <= CFG_VOXELS_X;
        cfg_data             <= '0;
        voxel_ch.valid       <= 1'b0;
        voxel_ch.mode        <= MODE_ACCUM;
        voxel_ch.coord_x     <= '0;
        voxel_ch.coord_y     <= '0;
        voxel_ch.coord_z     <= '0;
        voxel_ch.voxel_value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_accumulate_and_read();
        test_degenerate_grids();
        test_random_grids();
        test_output_backpressure();
        test_steady_stream();

        if (mismatches == 0 && pending_reads.size() == 0)
            $display("PASS voxel_density_binning");
        else
            $display("FAIL voxel_density_binning");
        $finish;
    end

endmodule

// File: voxel_density_binning.f
hdl/vdb_pkg.sv
hdl/vdb_if.sv
hdl/vdb_div_lane.sv
hdl/voxel_density_binning.sv
hdl/vdb_checker.sv
bench/testbench.sv
